### hdl/lsia_pkg.sv
// Package for the LIFO stack with indexed access.
// Holds field widths, operation and status codes, and the control structs
// shared by the controller, the datapath and the top level.
package lsia_pkg;

	localparam int OP_W    = 2;
	localparam int POS_W   = 3;
	localparam int VAL_W   = 32;
	localparam int ST_W    = 2;
	localparam int CNT_W   = 4;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd3;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [ST_W-1:0] ST_BADPOS    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic load_out;
	} lsia_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} lsia_sts_t;

endpackage

### hdl/lsia_ctrl.sv
// Controller state machine for the LIFO stack with indexed access.
// Sequences the clearing pass, item acceptance and result hand-off.
// Depends on lsia_pkg for the command and status structs.
module lsia_ctrl
	import lsia_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lsia_sts_t sts,
	output lsia_cmd_t cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_FETCH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_FETCH;
				end
			end
			S_FETCH: begin
				// The memory read is registered; move it out once the output stage is free.
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/lsia_dp.sv
// Datapath for the LIFO stack with indexed access: slot memory, fill level,
// operation decode, clearing counter and the output register.
// Depends on lsia_pkg for widths, codes and the control structs.
module lsia_dp
	import lsia_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lsia_cmd_t               cmd,
	output lsia_sts_t               sts,
	input  logic [OP_W-1:0]         operation,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [VAL_W-1:0] read_value,
	output logic [ST_W-1:0]         status,
	output logic [CNT_W-1:0]        item_count,
	output logic                    is_empty,
	output logic                    is_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [VAL_W-1:0] mem [DEPTH];

	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       fill_d;
	logic [CW-1:0]       fill_m1;
	logic [AW-1:0]       clr_q;
	logic [AW+POS_W-1:0] pos_ext;
	logic [CW+CNT_W-1:0] cnt_ext;
	logic                pos_bad;
	logic                empty_now;
	logic                full_now;

	logic             mem_en;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [VAL_W-1:0] mem_wdata;
	logic [ST_W-1:0]  st_d;
	logic             use_rd_d;

	logic [VAL_W-1:0] rd_s1;
	logic [ST_W-1:0]  st_s1;
	logic             use_rd_s1;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_rd_q;
	logic [ST_W-1:0]         out_st_q;
	logic [CNT_W-1:0]        out_cnt_q;
	logic                    out_empty_q;
	logic                    out_full_q;

	assign pos_ext   = (AW + POS_W)'(position);
	assign pos_bad   = 32'(position) >= DEPTH;
	assign empty_now = fill_q == '0;
	assign full_now  = fill_q == CW'(DEPTH);
	assign fill_m1   = fill_q - 1'b1;
	assign cnt_ext   = (CW + CNT_W)'(fill_q);

	// Every operation touches at most one slot, so one read-first port serves all.
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = clr_q;
		mem_wdata = '0;
		st_d      = ST_OK;
		use_rd_d  = 1'b0;
		fill_d    = fill_q;
		if (cmd.clr_step) begin
			mem_en = 1'b1;
			mem_we = 1'b1;
		end else if (cmd.accept) begin
			unique case (operation)
				OP_PUSH: begin
					if (full_now) begin
						st_d = ST_OVERFLOW;
					end else begin
						mem_en    = 1'b1;
						mem_we    = 1'b1;
						mem_addr  = fill_q[AW-1:0];
						mem_wdata = value;
						fill_d    = fill_q + 1'b1;
					end
				end
				OP_POP: begin
					if (empty_now) begin
						st_d = ST_UNDERFLOW;
					end else begin
						mem_en   = 1'b1;
						mem_we   = 1'b1;
						mem_addr = fill_m1[AW-1:0];
						use_rd_d = 1'b1;
						fill_d   = fill_m1;
					end
				end
				OP_PEEK: begin
					if (empty_now) begin
						st_d = ST_UNDERFLOW;
					end else if (pos_bad) begin
						st_d = ST_BADPOS;
					end else begin
						mem_en   = 1'b1;
						mem_addr = pos_ext[AW-1:0];
						use_rd_d = 1'b1;
					end
				end
				OP_WRITE: begin
					if (pos_bad) begin
						st_d = ST_BADPOS;
					end else begin
						mem_en    = 1'b1;
						mem_we    = 1'b1;
						mem_addr  = pos_ext[AW-1:0];
						mem_wdata = value;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_en) begin
			if (mem_we) begin
				mem[mem_addr] <= mem_wdata;
			end
			rd_s1 <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			st_s1     <= st_d;
			use_rd_s1 <= use_rd_d;
		end
		if (cmd.load_out) begin
			out_rd_q    <= use_rd_s1 ? signed'(rd_s1) : '0;
			out_st_q    <= st_s1;
			out_cnt_q   <= cnt_ext[CNT_W-1:0];
			out_empty_q <= empty_now;
			out_full_q  <= full_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last = clr_q == AW'(DEPTH - 1);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign read_value = out_rd_q;
	assign status     = out_st_q;
	assign item_count = out_cnt_q;
	assign is_empty   = out_empty_q;
	assign is_full    = out_full_q;

endmodule

### hdl/lifo_stack_with_indexed_access_top.sv
// LIFO stack of DEPTH signed 32-bit words with push, pop, peek and overwrite
// at an absolute slot. Each accepted word yields one result word. An item
// first accesses the single-port slot memory, then its registered read data
// moves into the output register once that register is free; no new word is
// accepted until then. After reset the block runs a clearing pass that zeroes
// every slot, and s_tready stays low until it ends.
// Depends on lsia_pkg, lsia_ctrl and lsia_dp.
module lifo_stack_with_indexed_access_top
	import lsia_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [1:0] operation, [4:2] position, [36:5] value, [39:37] zero
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [31:0] read_value, [33:32] status, [37:34] item_count, [38] is_empty, [39] is_full
	output logic [M_DATA_W-1:0] m_tdata
);

	lsia_cmd_t cmd;
	lsia_sts_t sts;

	logic signed [VAL_W-1:0] read_value;
	logic [ST_W-1:0]         status;
	logic [CNT_W-1:0]        item_count;
	logic                    is_empty;
	logic                    is_full;

	lsia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsia_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (s_tdata[1:0]),
		.position   (s_tdata[4:2]),
		.value      (signed'(s_tdata[36:5])),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.read_value (read_value),
		.status     (status),
		.item_count (item_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	assign m_tdata = {is_full, is_empty, item_count, status, read_value};

	// Only one item is in flight, so an accepted word drops ready the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while one is in flight");

	// A failed operation never returns a stored word.
	a_error_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[33:32] != ST_OK) |-> m_tdata[31:0] == '0)
		else $error("nonzero read value with error status");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[38] && m_tdata[39]))
		else $error("stack reported both empty and full");

endmodule
